// ===== design/tcce_pkg.sv =====
// Shared constants, types and codes of the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_POS = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_BASE    = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP     = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_SPAN     = ADDR_W'(COLUMNS - 1);

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CLEAR_ATTR   = 8'h0F;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [2:0] {
    CMD_PUTC,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        glyph;
    logic [ADDR_W-1:0] index;
    logic              index_ok;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } back_state_t;

endpackage

// ===== design/text_console_cursor_engine_unit.sv =====
// Top level of the text console cursor engine: front end, command queue and back end.
// A request passes the command queue, then the result register; an in-range read also the
// memory read register. Throughput: one put, backspace or no-op per cycle while results are
// taken; such a read holds the back end for its data, a scroll while it blanks a row, a
// clear while it blanks every cell, each one cell per cycle through the single memory write
// port. Reset: synchronous; a clearing pass follows, during which no request is taken.
`timescale 1ns / 1ps

module text_console_cursor_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code [7:0], cell_index [18:8], zeros above
  input  logic [1:0]  s_tuser,   // req_type [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // cursor_row [4:0], cursor_col [11:5], cursor_pos [22:12],
                                 // read_data [38:23], zero [39]
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]                    text_attribute;
  logic                          init_busy;
  logic                          q_push;
  logic                          q_ready;
  logic                          q_valid;
  logic                          q_pop;
  tcce_pkg::cmd_t                push_cmd;
  tcce_pkg::cmd_t                head_cmd;
  logic [tcce_pkg::ROW_W-1:0]    out_row;
  logic [tcce_pkg::COL_W-1:0]    out_col;
  logic [tcce_pkg::ADDR_W-1:0]   out_pos;
  logic [tcce_pkg::CELL_W-1:0]   out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcce_pkg::ATTR_RESET;
    end else if (cfg_wen) begin
      text_attribute <= cfg_wdata;
    end
  end

  tcce_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_ready   (q_ready),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tcce_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .valid    (q_valid),
    .pop      (q_pop),
    .head_cmd (head_cmd)
  );

  tcce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .attr      (text_attribute),
    .m_tready  (m_tready),
    .out_valid (m_tvalid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_pos   (out_pos),
    .out_data  (out_data),
    .init_busy (init_busy)
  );

  assign m_tdata = {1'b0, out_data, out_pos, out_col, out_row};

`ifndef NO_ASSERTIONS
  a_no_accept_during_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !s_tready)
    else $error("request taken during the clearing pass");

  a_cursor_on_grid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:0] <= tcce_pkg::LAST_ROW) && (m_tdata[11:5] <= tcce_pkg::LAST_COL))
    else $error("reported cursor is off the grid");

  a_cursor_pos_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[22:12] ==
                  tcce_pkg::ADDR_W'(m_tdata[4:0] * tcce_pkg::COLUMNS + m_tdata[11:5])))
    else $error("linear cursor position disagrees with row and column");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back end took a command from an empty queue");
`endif

endmodule

// ===== design/tcce_front.sv =====
// Front end: accepts requests and classifies them into commands.
`timescale 1ns / 1ps

module tcce_front (
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,
  input  logic [1:0]                  s_tuser,
  input  logic                        q_ready,
  input  logic                        init_busy,
  output logic                        q_push,
  output tcce_pkg::cmd_t              q_cmd
);

  logic [7:0]                  glyph;
  logic [tcce_pkg::ADDR_W-1:0] index;

  assign glyph    = s_tdata[7:0];
  assign index    = s_tdata[18:8];
  assign s_tready = q_ready && !init_busy;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_cmd.glyph    = glyph;
    q_cmd.index    = index;
    q_cmd.index_ok = (index <= tcce_pkg::LAST_CELL);
    unique case (s_tuser)
      tcce_pkg::REQ_PUT: begin
        if (glyph == tcce_pkg::CH_NEWLINE) begin
          q_cmd.kind = tcce_pkg::CMD_NEWLINE;
        end else if (glyph == tcce_pkg::CH_BACKSPACE) begin
          q_cmd.kind = tcce_pkg::CMD_BACKSPACE;
        end else begin
          q_cmd.kind = tcce_pkg::CMD_PUTC;
        end
      end
      tcce_pkg::REQ_CLEAR: q_cmd.kind = tcce_pkg::CMD_CLEAR;
      tcce_pkg::REQ_READ:  q_cmd.kind = tcce_pkg::CMD_READ;
      default:             q_cmd.kind = tcce_pkg::CMD_NOP;
    endcase
  end

endmodule

// ===== design/tcce_cmd_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module tcce_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcce_pkg::cmd_t push_cmd,
  output logic           ready,
  output logic           valid,
  input  logic           pop,
  output tcce_pkg::cmd_t head_cmd
);

  tcce_pkg::cmd_t              entries [tcce_pkg::QDEPTH];
  logic [tcce_pkg::QPTR_W-1:0] wr_ptr;
  logic [tcce_pkg::QPTR_W-1:0] rd_ptr;
  logic [tcce_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign ready    = (count != tcce_pkg::QCNT_W'(tcce_pkg::QDEPTH));
  assign valid    = (count != '0);
  assign head_cmd = entries[rd_ptr];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == tcce_pkg::QPTR_W'(tcce_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == tcce_pkg::QPTR_W'(tcce_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/tcce_back.sv =====
// Back end: cursor state, cell memory with rotating top row, sweeps and result register.
`timescale 1ns / 1ps

module tcce_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  tcce_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic [7:0]                    attr,
  input  logic                          m_tready,
  output logic                          out_valid,
  output logic [tcce_pkg::ROW_W-1:0]    out_row,
  output logic [tcce_pkg::COL_W-1:0]    out_col,
  output logic [tcce_pkg::ADDR_W-1:0]   out_pos,
  output logic [tcce_pkg::CELL_W-1:0]   out_data,
  output logic                          init_busy
);

  logic [tcce_pkg::CELL_W-1:0] mem [tcce_pkg::CELLS];

  tcce_pkg::back_state_t       state;
  tcce_pkg::back_state_t       state_next;
  logic [tcce_pkg::ROW_W-1:0]  cur_row;
  logic [tcce_pkg::ROW_W-1:0]  cur_row_next;
  logic [tcce_pkg::COL_W-1:0]  cur_col;
  logic [tcce_pkg::COL_W-1:0]  cur_col_next;
  logic [tcce_pkg::ADDR_W-1:0] cur_pos;
  logic [tcce_pkg::ADDR_W-1:0] cur_pos_next;
  logic [tcce_pkg::ADDR_W-1:0] top_base;
  logic [tcce_pkg::ADDR_W-1:0] top_base_next;
  logic [tcce_pkg::ADDR_W-1:0] sweep_addr;
  logic [tcce_pkg::ADDR_W-1:0] sweep_addr_next;
  logic [tcce_pkg::ADDR_W-1:0] sweep_end;
  logic [tcce_pkg::ADDR_W-1:0] sweep_end_next;
  logic [7:0]                  sweep_attr;
  logic [7:0]                  sweep_attr_next;
  logic                        init_busy_next;

  logic                        wr_en;
  logic [tcce_pkg::ADDR_W-1:0] wr_addr;
  logic [tcce_pkg::CELL_W-1:0] wr_data;
  logic                        rd_en;
  logic [tcce_pkg::ADDR_W-1:0] rd_addr;
  logic [tcce_pkg::CELL_W-1:0] rd_data;

  logic                        out_load;
  logic [tcce_pkg::CELL_W-1:0] out_data_next;
  logic                        out_free;
  logic [tcce_pkg::ADDR_W-1:0] phys_cur;
  logic [tcce_pkg::ADDR_W-1:0] phys_prev;
  logic [tcce_pkg::ADDR_W-1:0] phys_read;

  // Logical cell index to physical address, rows rotated by the top base.
  function automatic logic [tcce_pkg::ADDR_W-1:0] phys_addr(
    input logic [tcce_pkg::ADDR_W-1:0] lin,
    input logic [tcce_pkg::ADDR_W-1:0] base
  );
    logic [tcce_pkg::ADDR_W:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= (tcce_pkg::ADDR_W + 1)'(tcce_pkg::CELLS)) begin
      sum = sum - (tcce_pkg::ADDR_W + 1)'(tcce_pkg::CELLS);
    end
    return sum[tcce_pkg::ADDR_W-1:0];
  endfunction

  assign phys_cur  = phys_addr(cur_pos, top_base);
  assign phys_prev = phys_addr(cur_pos - 1'b1, top_base);
  assign phys_read = phys_addr(cmd.index, top_base);
  assign out_free  = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcce_pkg::ST_CLEAR;
      cur_row    <= '0;
      cur_col    <= '0;
      cur_pos    <= '0;
      top_base   <= '0;
      sweep_addr <= '0;
      sweep_end  <= tcce_pkg::LAST_CELL;
      sweep_attr <= tcce_pkg::ATTR_RESET;
      init_busy  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      cur_pos    <= cur_pos_next;
      top_base   <= top_base_next;
      sweep_addr <= sweep_addr_next;
      sweep_end  <= sweep_end_next;
      sweep_attr <= sweep_attr_next;
      init_busy  <= init_busy_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row  <= cur_row_next;
      out_col  <= cur_col_next;
      out_pos  <= cur_pos_next;
      out_data <= out_data_next;
    end
  end

  always_comb begin
    state_next      = state;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    cur_pos_next    = cur_pos;
    top_base_next   = top_base;
    sweep_addr_next = sweep_addr;
    sweep_end_next  = sweep_end;
    sweep_attr_next = sweep_attr;
    init_busy_next  = init_busy;
    wr_en           = 1'b0;
    wr_addr         = phys_cur;
    wr_data         = {attr, cmd.glyph};
    rd_en           = 1'b0;
    rd_addr         = phys_read;
    out_load        = 1'b0;
    out_data_next   = '0;
    cmd_pop         = 1'b0;
    unique case (state) inside
      tcce_pkg::ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop  = 1'b1;
          out_load = 1'b1;
          case (cmd.kind)
            tcce_pkg::CMD_PUTC: begin
              wr_en = 1'b1;
              if (cur_col == tcce_pkg::LAST_COL) begin
                cur_col_next = '0;
                if (cur_row == tcce_pkg::LAST_ROW) begin
                  cur_pos_next    = tcce_pkg::LAST_ROW_POS;
                  sweep_addr_next = top_base;
                  sweep_end_next  = top_base + tcce_pkg::ROW_SPAN;
                  sweep_attr_next = attr;
                  top_base_next   = (top_base == tcce_pkg::LAST_BASE) ? '0
                                    : top_base + tcce_pkg::ROW_STEP;
                  state_next      = tcce_pkg::ST_SCROLL;
                end else begin
                  cur_row_next = cur_row + 1'b1;
                  cur_pos_next = cur_pos + 1'b1;
                end
              end else begin
                cur_col_next = cur_col + 1'b1;
                cur_pos_next = cur_pos + 1'b1;
              end
            end
            tcce_pkg::CMD_NEWLINE: begin
              cur_col_next = '0;
              if (cur_row == tcce_pkg::LAST_ROW) begin
                cur_pos_next    = tcce_pkg::LAST_ROW_POS;
                sweep_addr_next = top_base;
                sweep_end_next  = top_base + tcce_pkg::ROW_SPAN;
                sweep_attr_next = attr;
                top_base_next   = (top_base == tcce_pkg::LAST_BASE) ? '0
                                  : top_base + tcce_pkg::ROW_STEP;
                state_next      = tcce_pkg::ST_SCROLL;
              end else begin
                cur_row_next = cur_row + 1'b1;
                cur_pos_next = cur_pos - tcce_pkg::ADDR_W'(cur_col) + tcce_pkg::ROW_STEP;
              end
            end
            tcce_pkg::CMD_BACKSPACE: begin
              if (cur_col != '0) begin
                wr_en        = 1'b1;
                wr_addr      = phys_prev;
                wr_data      = {attr, tcce_pkg::CH_SPACE};
                cur_col_next = cur_col - 1'b1;
                cur_pos_next = cur_pos - 1'b1;
              end
            end
            tcce_pkg::CMD_CLEAR: begin
              cur_row_next    = '0;
              cur_col_next    = '0;
              cur_pos_next    = '0;
              top_base_next   = '0;
              sweep_addr_next = '0;
              sweep_end_next  = tcce_pkg::LAST_CELL;
              state_next      = tcce_pkg::ST_CLEAR;
            end
            tcce_pkg::CMD_READ: begin
              if (cmd.index_ok) begin
                rd_en      = 1'b1;
                out_load   = 1'b0;
                state_next = tcce_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tcce_pkg::ST_READ: begin
        out_load      = 1'b1;
        out_data_next = rd_data;
        state_next    = tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_SCROLL, tcce_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_addr;
        wr_data = (state == tcce_pkg::ST_CLEAR) ? {tcce_pkg::CLEAR_ATTR, tcce_pkg::CH_SPACE}
                                                : {sweep_attr, tcce_pkg::CH_SPACE};
        if (sweep_addr == sweep_end) begin
          state_next     = tcce_pkg::ST_IDLE;
          init_busy_next = 1'b0;
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end
      default: begin
        state_next = tcce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== bench/tb_text_console_cursor_engine_unit.sv =====
// Self-checking testbench for the text console cursor engine: random traffic, predictor, scoreboard.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_unit;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int SETTLE_CYCLES = tcce_pkg::CELLS + 100;
  localparam int TAIL_CYCLES   = 50;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 65;

  typedef struct {
    logic [1:0]                  kind;
    logic [7:0]                  code;
    logic [tcce_pkg::ADDR_W-1:0] index;
  } console_req_t;

  typedef struct {
    logic [tcce_pkg::ROW_W-1:0]  row;
    logic [tcce_pkg::COL_W-1:0]  col;
    logic [tcce_pkg::ADDR_W-1:0] pos;
    logic [tcce_pkg::CELL_W-1:0] data;
  } console_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_wen = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  text_console_cursor_engine_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted console state.
  logic [tcce_pkg::CELL_W-1:0] screen_image [tcce_pkg::CELLS];
  logic [tcce_pkg::ROW_W-1:0]  pred_row;
  logic [tcce_pkg::COL_W-1:0]  pred_col;
  logic [7:0]                  pred_attr;

  console_req_t pending_reqs [$];
  console_res_t expected_cursor [$];
  console_req_t live_req;

  bit calm_src;
  bit calm_sink;
  int src_wait;
  int sink_wait;
  int error_count;
  int result_count;
  int cycle_count;
  int n_put, n_scroll, n_clear, n_read, n_ignored, n_attr;

  function automatic int draw_gap(bit calm);
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH in result %0d, %s: got 0x%0h, expected 0x%0h",
             result_count, field, got, want);
    error_count++;
  endtask

  task automatic predict_console(console_req_t r);
    console_res_t e;
    int at;
    e.data = '0;
    case (r.kind)
      tcce_pkg::REQ_PUT: begin
        n_put++;
        at = int'(pred_row) * tcce_pkg::COLUMNS + int'(pred_col);
        if (r.code == tcce_pkg::CH_NEWLINE) begin
          pred_col = '0;
          pred_row = pred_row + 1'b1;
        end else if (r.code == tcce_pkg::CH_BACKSPACE) begin
          if (pred_col != 0) begin
            pred_col = pred_col - 1'b1;
            screen_image[at - 1] = {pred_attr, tcce_pkg::CH_SPACE};
          end
        end else begin
          screen_image[at] = {pred_attr, r.code};
          pred_col = pred_col + 1'b1;
          if (pred_col >= tcce_pkg::COLUMNS) begin
            pred_col = '0;
            pred_row = pred_row + 1'b1;
          end
        end
        if (pred_row >= tcce_pkg::ROWS) begin
          n_scroll++;
          for (int i = 0; i < tcce_pkg::CELLS - tcce_pkg::COLUMNS; i++) begin
            screen_image[i] = screen_image[i + tcce_pkg::COLUMNS];
          end
          for (int i = tcce_pkg::CELLS - tcce_pkg::COLUMNS; i < tcce_pkg::CELLS; i++) begin
            screen_image[i] = {pred_attr, tcce_pkg::CH_SPACE};
          end
          pred_row = tcce_pkg::LAST_ROW;
          pred_col = '0;
        end
      end
      tcce_pkg::REQ_CLEAR: begin
        n_clear++;
        for (int i = 0; i < tcce_pkg::CELLS; i++) begin
          screen_image[i] = {tcce_pkg::CLEAR_ATTR, tcce_pkg::CH_SPACE};
        end
        pred_row = '0;
        pred_col = '0;
      end
      tcce_pkg::REQ_READ: begin
        n_read++;
        if (r.index < tcce_pkg::CELLS) begin
          e.data = screen_image[r.index];
        end
      end
      default: begin
        n_ignored++;
      end
    endcase
    e.row = pred_row;
    e.col = pred_col;
    e.pos = tcce_pkg::ADDR_W'(int'(pred_row) * tcce_pkg::COLUMNS + int'(pred_col));
    expected_cursor.push_back(e);
  endtask

  task automatic push_req(logic [1:0] kind, logic [7:0] code,
                          logic [tcce_pkg::ADDR_W-1:0] index);
    console_req_t r;
    r.kind = kind;
    r.code = code;
    r.index = index;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [tcce_pkg::ADDR_W-1:0] pick_cell();
    case ($urandom_range(0, 2))
      0: return tcce_pkg::ADDR_W'($urandom_range(0, 2047));
      1: return tcce_pkg::ADDR_W'($urandom_range(int'(tcce_pkg::LAST_BASE),
                                                 int'(tcce_pkg::LAST_CELL)));
      default: return tcce_pkg::ADDR_W'($urandom_range(0, tcce_pkg::CELLS - 1));
    endcase
  endfunction

  function automatic logic [7:0] any_code();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed text: runs of characters, line breaks and corrections,
  // with reads sprinkled in, rare clears and some noise.
  task automatic queue_traffic(int target, bit force_scroll);
    int made;
    int len;
    int pick;
    made = 0;
    if (force_scroll) begin
      for (int i = 0; i < tcce_pkg::ROWS + 2; i++) begin
        push_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, pick_cell());
      end
      made = tcce_pkg::ROWS + 2;
    end
    while (made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        len = ($urandom_range(0, 9) == 0) ? tcce_pkg::ROWS + 1 : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) push_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, pick_cell());
        made += len;
      end else if (pick < 50) begin
        len = ($urandom_range(0, 7) == 0)
              ? $urandom_range(tcce_pkg::COLUMNS - 10, tcce_pkg::COLUMNS + 10)
              : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) push_req(tcce_pkg::REQ_PUT, any_code(), pick_cell());
        made += len;
      end else if (pick < 60) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) push_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_BACKSPACE, pick_cell());
        made += len;
      end else if (pick < 82) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_req(tcce_pkg::REQ_READ, any_code(), pick_cell());
        made += len;
      end else if (pick < 85) begin
        push_req(tcce_pkg::REQ_CLEAR, any_code(), pick_cell());
        made++;
      end else if (pick < 90) begin
        push_req(REQ_NONE, any_code(), pick_cell());
      end else begin
        push_req(2'($urandom_range(0, 2)), any_code(), pick_cell());
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_reqs.size() != 0 || s_tvalid || expected_cursor.size() != 0);
  endtask

  task automatic write_attribute(logic [7:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    pred_attr = value;
    n_attr++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_console(live_req);
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          live_req = pending_reqs.pop_front();
          s_tdata <= {5'b0, live_req.index, live_req.code};
          s_tuser <= live_req.kind;
          s_tvalid <= 1'b1;
          src_wait = draw_gap(calm_src);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and scoreboard.
  always @(posedge clk) begin
    console_res_t e;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_count++;
        if (expected_cursor.size() == 0) begin
          report_mismatch("result with no request pending", int'(m_tdata[22:12]), -1);
        end else begin
          e = expected_cursor.pop_front();
          if (m_tdata[4:0] !== e.row)
            report_mismatch("cursor_row", int'(m_tdata[4:0]), int'(e.row));
          if (m_tdata[11:5] !== e.col)
            report_mismatch("cursor_col", int'(m_tdata[11:5]), int'(e.col));
          if (m_tdata[22:12] !== e.pos)
            report_mismatch("cursor_pos", int'(m_tdata[22:12]), int'(e.pos));
          if (m_tdata[38:23] !== e.data)
            report_mismatch("read_data", int'(m_tdata[38:23]), int'(e.data));
        end
        sink_wait = draw_gap(calm_sink);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_cursor.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0] attr_plan [6];
    attr_plan = '{8'h00, 8'hFF, 8'h00, 8'h70, 8'h00, tcce_pkg::ATTR_RESET};
    attr_plan[2] = 8'($urandom_range(1, 254));
    attr_plan[4] = 8'($urandom_range(1, 254));
    for (int i = 0; i < tcce_pkg::CELLS; i++) begin
      screen_image[i] = {tcce_pkg::CLEAR_ATTR, tcce_pkg::CH_SPACE};
    end
    pred_row = '0;
    pred_col = '0;
    pred_attr = tcce_pkg::ATTR_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: grid corners, out-of-range reads, glyph extremes, backspace at
    // and away from column zero, newline, the unused request type, clear.
    push_req(tcce_pkg::REQ_READ, 8'h00, '0);
    push_req(tcce_pkg::REQ_READ, 8'hFF, tcce_pkg::LAST_CELL);
    push_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ADDR_W'(tcce_pkg::CELLS));
    push_req(tcce_pkg::REQ_READ, 8'hFF, '1);
    push_req(tcce_pkg::REQ_PUT, 8'h41, '0);
    push_req(tcce_pkg::REQ_PUT, 8'hFF, '1);
    push_req(tcce_pkg::REQ_PUT, 8'h00, '0);
    push_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ADDR_W'(1));
    push_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_BACKSPACE, '0);
    push_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ADDR_W'(2));
    push_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ADDR_W'(1));
    push_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, '1);
    push_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_BACKSPACE, '0);
    push_req(tcce_pkg::REQ_PUT, 8'h7F, '0);
    push_req(tcce_pkg::REQ_PUT, 8'h80, '0);
    push_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ROW_STEP);
    push_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS + 1));
    push_req(REQ_NONE, 8'hFF, '1);
    push_req(tcce_pkg::REQ_CLEAR, 8'hFF, '1);
    push_req(tcce_pkg::REQ_READ, 8'h00, '0);
    push_req(tcce_pkg::REQ_READ, 8'h00, tcce_pkg::ROW_STEP);
    push_req(tcce_pkg::REQ_PUT, tcce_pkg::CH_SPACE, '0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      write_attribute(attr_plan[phase]);
      calm_src = (phase == 1) || (phase == 3);
      calm_sink = (phase == 1) || (phase == 4);
      queue_traffic(PHASE_ITEMS, phase == 0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_cursor.size() != 0) begin
      report_mismatch("results never delivered", 0, expected_cursor.size());
    end
    $display("Checked %0d results: %0d puts with %0d scrolls, %0d clears, %0d reads, %0d ignored.",
             result_count, n_put, n_scroll, n_clear, n_read, n_ignored);
    $display("The text attribute was written %0d times, 0x00 and 0xFF among the values.",
             n_attr);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
